[hw/rtl/port_debounce_click_long_press_macros.svh]
// Assertion macros for the port debounce, click and long-press block.
// Used by modules that check their own logic; needs clk_i and rst_ni in scope.
`ifndef PORT_DEBOUNCE_CLICK_LONG_PRESS_MACROS_SVH
`define PORT_DEBOUNCE_CLICK_LONG_PRESS_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PDCLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define PDCLP_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pdclp_pkg.sv]
// Shared types and constants for the port debounce, click and long-press block.
// No dependencies.
package pdclp_pkg;

  typedef enum logic [2:0] {
    CFG_USB_THRESHOLD     = 3'd0,
    CFG_DEBOUNCE_TICKS    = 3'd1,
    CFG_PRESS_GAP_TICKS   = 3'd2,
    CFG_RELEASE_GAP_TICKS = 3'd3,
    CFG_CLICK_LIMIT       = 3'd4,
    CFG_HOLD_ON_MIN       = 3'd5,
    CFG_HOLD_ON_MAX       = 3'd6,
    CFG_HOLD_OFF_TICKS    = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned AdcW     = 12;
  localparam int unsigned BatW     = 16;
  localparam int unsigned ProdW    = AdcW + BatW;
  localparam int unsigned HoldW    = 12;
  localparam int unsigned GapW     = 8;
  localparam int unsigned CntW     = 4;
  localparam int unsigned SampleW  = 4;

  localparam int unsigned SbMic  = 0;
  localparam int unsigned SbUsb  = 1;
  localparam int unsigned SbKey  = 2;
  localparam int unsigned SbHeat = 3;

  localparam logic [HoldW-1:0] HoldMax = {HoldW{1'b1}};

  typedef struct packed {
    logic [15:0]      usb_threshold;
    logic [CntW-1:0]  debounce_ticks;
    logic [GapW-1:0]  press_gap_ticks;
    logic [GapW-1:0]  release_gap_ticks;
    logic [CntW-1:0]  click_limit;
    logic [HoldW-1:0] hold_on_min;
    logic [HoldW-1:0] hold_on_max;
    logic [HoldW-1:0] hold_off_ticks;
  } cfg_t;

  typedef struct packed {
    logic out_start;
    logic out_stop_event;
    logic usb_attach_event;
    logic usb_detach_event;
    logic usb_in;
    logic heat_in;
    logic power_on;
    logic display_on_event;
    logic sleep_event;
    logic gear_high;
    logic gear_toggle_event;
  } res_t;

endpackage

[hw/rtl/pdclp_level.sv]
// Sample word builder: scales the USB reading and packs it with three pins.
// Depends on pdclp_pkg.
module pdclp_level (
  input  logic                             mic_pin_i,
  input  logic                             key_pin_i,
  input  logic                             heat_pin_i,
  input  logic [pdclp_pkg::AdcW-1:0]       usb_adc_i,
  input  logic [pdclp_pkg::BatW-1:0]       bat_volt_i,
  input  logic [15:0]                      usb_threshold_i,
  output logic [pdclp_pkg::SampleW-1:0]    sample_o
);

  logic [pdclp_pkg::ProdW-1:0] prod;
  logic [15:0]                 level;

  assign prod  = {{pdclp_pkg::BatW{1'b0}}, usb_adc_i} * {{pdclp_pkg::AdcW{1'b0}}, bat_volt_i};
  assign level = prod[pdclp_pkg::ProdW-1:pdclp_pkg::AdcW];

  always_comb begin
    sample_o                     = '0;
    sample_o[pdclp_pkg::SbMic]  = mic_pin_i;
    sample_o[pdclp_pkg::SbUsb]  = (level >= usb_threshold_i);
    sample_o[pdclp_pkg::SbKey]  = ~key_pin_i;
    sample_o[pdclp_pkg::SbHeat] = heat_pin_i;
  end

endmodule

[hw/rtl/pdclp_ctrl.sv]
// Tick controller: debounce, edge events, click counting and long-press power.
// Depends on pdclp_pkg and the assertion macro header.
`include "port_debounce_click_long_press_macros.svh"

module pdclp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [pdclp_pkg::SampleW-1:0] sample_i,
  input  pdclp_pkg::cfg_t               cfg_i,
  output pdclp_pkg::res_t               res_o
);

  logic [pdclp_pkg::SampleW-1:0] acc_q, acc_d;
  logic [pdclp_pkg::CntW-1:0]    dcnt_q, dcnt_d;
  logic                          held_q, held_d;
  logic [pdclp_pkg::HoldW-1:0]   hold_q, hold_d;
  logic [pdclp_pkg::GapW-1:0]    gap_q, gap_d;
  logic [pdclp_pkg::CntW-1:0]    click_q, click_d;
  logic                          power_q, power_d;
  logic                          gear_q, gear_d;
  logic                          fo_out_q, fo_out_d;
  logic                          fo_usb_q, fo_usb_d;
  logic                          fo_heat_q, fo_heat_d;
  logic [pdclp_pkg::SampleW-1:0] rise, fall;
  logic                          accept;
  logic                          ev_stop, ev_att, ev_det, ev_disp, ev_sleep, ev_gear;

  always_comb begin
    acc_d     = acc_q;
    dcnt_d    = dcnt_q;
    held_d    = held_q;
    hold_d    = hold_q;
    gap_d     = gap_q;
    click_d   = click_q;
    power_d   = power_q;
    gear_d    = gear_q;
    fo_out_d  = fo_out_q;
    fo_usb_d  = fo_usb_q;
    fo_heat_d = fo_heat_q;
    ev_stop   = 1'b0;
    ev_att    = 1'b0;
    ev_det    = 1'b0;
    ev_disp   = 1'b0;
    ev_sleep  = 1'b0;
    ev_gear   = 1'b0;
    rise      = sample_i & ~acc_q;
    fall      = ~sample_i & acc_q;
    accept    = 1'b0;

    if (sample_i != acc_q) begin
      if (dcnt_q < cfg_i.debounce_ticks) begin
        dcnt_d = dcnt_q + 1'b1;
      end else begin
        accept = 1'b1;
      end
    end else begin
      dcnt_d = '0;
    end

    if (accept) begin
      if (rise[pdclp_pkg::SbMic]) begin
        power_d  = 1'b1;
        fo_out_d = 1'b1;
      end
      if (fall[pdclp_pkg::SbMic]) begin
        fo_out_d = 1'b0;
        ev_stop  = 1'b1;
      end
      if (rise[pdclp_pkg::SbKey]) begin
        gap_d  = cfg_i.press_gap_ticks;
        held_d = 1'b1;
        if (click_q < cfg_i.click_limit) begin
          click_d = click_q + 1'b1;
        end
      end
      if (fall[pdclp_pkg::SbKey]) begin
        gap_d  = cfg_i.release_gap_ticks;
        held_d = 1'b0;
      end
      if (rise[pdclp_pkg::SbUsb]) begin
        fo_usb_d = 1'b1;
        ev_att   = 1'b1;
      end
      if (fall[pdclp_pkg::SbUsb]) begin
        fo_usb_d = 1'b0;
        ev_det   = 1'b1;
      end
      if (rise[pdclp_pkg::SbHeat]) begin
        fo_heat_d = 1'b1;
      end
      if (fall[pdclp_pkg::SbHeat]) begin
        fo_heat_d = 1'b0;
      end
      dcnt_d = '0;
      acc_d  = sample_i;
    end

    if (held_d) begin
      if (hold_q < pdclp_pkg::HoldMax) begin
        hold_d = hold_q + 1'b1;
      end
      priority if (!power_d && hold_d >= cfg_i.hold_on_min && hold_d <= cfg_i.hold_on_max) begin
        ev_disp = 1'b1;
        power_d = 1'b1;
      end else if (hold_d >= cfg_i.hold_off_ticks) begin
        power_d  = 1'b0;
        ev_sleep = 1'b1;
      end else begin
        ev_sleep = 1'b0;
      end
    end else begin
      hold_d = '0;
    end

    if (gap_d != '0) begin
      gap_d = gap_d - 1'b1;
    end else begin
      if (click_d == pdclp_pkg::CntW'(1)) begin
        gear_d  = ~gear_q;
        ev_gear = 1'b1;
        if (!power_d) begin
          ev_disp = 1'b1;
        end
      end
      click_d = '0;
    end

    res_o.out_start         = fo_out_d;
    res_o.out_stop_event    = ev_stop;
    res_o.usb_attach_event  = ev_att;
    res_o.usb_detach_event  = ev_det;
    res_o.usb_in            = fo_usb_d;
    res_o.heat_in           = fo_heat_d;
    res_o.power_on          = power_d;
    res_o.display_on_event  = ev_disp;
    res_o.sleep_event       = ev_sleep;
    res_o.gear_high         = gear_d;
    res_o.gear_toggle_event = ev_gear;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      dcnt_q    <= '0;
      held_q    <= 1'b0;
      hold_q    <= '0;
      gap_q     <= '0;
      click_q   <= '0;
      power_q   <= 1'b0;
      gear_q    <= 1'b0;
      fo_out_q  <= 1'b0;
      fo_usb_q  <= 1'b0;
      fo_heat_q <= 1'b0;
    end else if (step_i) begin
      acc_q     <= acc_d;
      dcnt_q    <= dcnt_d;
      held_q    <= held_d;
      hold_q    <= hold_d;
      gap_q     <= gap_d;
      click_q   <= click_d;
      power_q   <= power_d;
      gear_q    <= gear_d;
      fo_out_q  <= fo_out_d;
      fo_usb_q  <= fo_usb_d;
      fo_heat_q <= fo_heat_d;
    end
  end

  `PDCLP_ASSERT(a_hold_idle, !held_q |-> (hold_q == '0), "hold count running without key held")
  `PDCLP_ASSERT(a_sleep_off, res_o.sleep_event |-> !res_o.power_on, "sleep event with power on")
  `PDCLP_ASSERT_NEXT(a_gear_flip, step_i && ev_gear, gear_q != $past(gear_q), "gear did not toggle")
  `PDCLP_ASSERT_NEXT(a_accept_word, step_i && accept, acc_q == $past(sample_i), "accepted word lost")

endmodule

[hw/rtl/port_debounce_click_long_press.sv]
// Top level of the port debounce, click and long-press block: config registers,
// input stage and result register. Depends on pdclp_pkg, pdclp_level, pdclp_ctrl.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid_i/cfg_ready_o, index, data      | in
//  in      | in_valid_i/in_ready_o, pins, adc, battery | in
//  out     | out_valid_o/out_ready_i, level and events | out
//
// One transaction per cycle while the output is not stalled; a result passes through the
// sample register, which takes the multiply and compare, and then the result register,
// which takes the tick controller's result.
// Reset clears all but the sample and result registers and loads the register defaults;
// cfg_ready_o is always high. A stall on the output holds the result and then the sample
// stage, and in_ready_o drops only when both are full.
module port_debounce_click_long_press (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pdclp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pdclp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mic_pin_i,
  input  logic                             key_pin_i,
  input  logic                             heat_pin_i,
  input  logic [pdclp_pkg::AdcW-1:0]       usb_adc_i,
  input  logic [pdclp_pkg::BatW-1:0]       bat_volt_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             out_start_o,
  output logic                             out_stop_event_o,
  output logic                             usb_attach_event_o,
  output logic                             usb_detach_event_o,
  output logic                             usb_in_o,
  output logic                             heat_in_o,
  output logic                             power_on_o,
  output logic                             display_on_event_o,
  output logic                             sleep_event_o,
  output logic                             gear_high_o,
  output logic                             gear_toggle_event_o
);

  pdclp_pkg::cfg_t               cfg_q;
  logic [pdclp_pkg::SampleW-1:0] sample;
  logic [pdclp_pkg::SampleW-1:0] sample_q;
  logic                          s1_valid_q;
  logic                          out_valid_q;
  logic                          out_free;
  logic                          step;
  pdclp_pkg::res_t               res;
  pdclp_pkg::res_t               res_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.usb_threshold     <= 16'd350;
      cfg_q.debounce_ticks    <= 4'd3;
      cfg_q.press_gap_ticks   <= 8'd50;
      cfg_q.release_gap_ticks <= 8'd30;
      cfg_q.click_limit       <= 4'd10;
      cfg_q.hold_on_min       <= 12'd300;
      cfg_q.hold_on_max       <= 12'd1000;
      cfg_q.hold_off_ticks    <= 12'd3000;
    end else if (cfg_valid_i) begin
      unique case (pdclp_pkg::cfg_idx_e'(cfg_index_i))
        pdclp_pkg::CFG_USB_THRESHOLD:     cfg_q.usb_threshold     <= cfg_data_i;
        pdclp_pkg::CFG_DEBOUNCE_TICKS:    cfg_q.debounce_ticks    <= cfg_data_i[3:0];
        pdclp_pkg::CFG_PRESS_GAP_TICKS:   cfg_q.press_gap_ticks   <= cfg_data_i[7:0];
        pdclp_pkg::CFG_RELEASE_GAP_TICKS: cfg_q.release_gap_ticks <= cfg_data_i[7:0];
        pdclp_pkg::CFG_CLICK_LIMIT:       cfg_q.click_limit       <= cfg_data_i[3:0];
        pdclp_pkg::CFG_HOLD_ON_MIN:       cfg_q.hold_on_min       <= cfg_data_i[11:0];
        pdclp_pkg::CFG_HOLD_ON_MAX:       cfg_q.hold_on_max       <= cfg_data_i[11:0];
        pdclp_pkg::CFG_HOLD_OFF_TICKS:    cfg_q.hold_off_ticks    <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  pdclp_level u_level (
    .mic_pin_i       (mic_pin_i),
    .key_pin_i       (key_pin_i),
    .heat_pin_i      (heat_pin_i),
    .usb_adc_i       (usb_adc_i),
    .bat_volt_i      (bat_volt_i),
    .usb_threshold_i (cfg_q.usb_threshold),
    .sample_o        (sample)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= sample;
    end
    if (step) begin
      res_q <= res;
    end
  end

  pdclp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (sample_q),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  assign out_valid_o         = out_valid_q;
  assign out_start_o         = res_q.out_start;
  assign out_stop_event_o    = res_q.out_stop_event;
  assign usb_attach_event_o  = res_q.usb_attach_event;
  assign usb_detach_event_o  = res_q.usb_detach_event;
  assign usb_in_o            = res_q.usb_in;
  assign heat_in_o           = res_q.heat_in;
  assign power_on_o          = res_q.power_on;
  assign display_on_event_o  = res_q.display_on_event;
  assign sleep_event_o       = res_q.sleep_event;
  assign gear_high_o         = res_q.gear_high;
  assign gear_toggle_event_o = res_q.gear_toggle_event;

endmodule

[verif/pdclp_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for port_debounce_click_long_press: watches the config, scan-tick and
// result channels, predicts each tick's result and compares it field by field.
// Depends on pdclp_pkg only; hands mismatch and pending counts to the testbench top.
module pdclp_result_checker
  import pdclp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                mic_pin_i,
  input  logic                key_pin_i,
  input  logic                heat_pin_i,
  input  logic [AdcW-1:0]     usb_adc_i,
  input  logic [BatW-1:0]     bat_volt_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  res_t                result_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned ResW = $bits(res_t);
  localparam cfg_t CfgReset = '{16'd350, 4'd3, 8'd50, 8'd30, 4'd10, 12'd300, 12'd1000,
                                12'd3000};

  string field_name [ResW] = '{"out_start", "out_stop_event", "usb_attach_event",
                               "usb_detach_event", "usb_in", "heat_in", "power_on",
                               "display_on_event", "sleep_event", "gear_high",
                               "gear_toggle_event"};

  cfg_t               cfg_q;
  logic [SampleW-1:0] accepted_q;
  logic [CntW-1:0]    bounce_q;
  logic               held_q;
  logic [HoldW-1:0]   hold_q;
  logic [GapW-1:0]    gap_q;
  logic [CntW-1:0]    clicks_q;
  logic               power_q, gear_q, out_q, usb_q, heat_q;
  res_t               predicted_results [$];
  res_t               want, got;

  initial mismatch_count_o = 0;
  initial pending_o = 0;

  task automatic load_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_USB_THRESHOLD:     cfg_q.usb_threshold     = data;
      CFG_DEBOUNCE_TICKS:    cfg_q.debounce_ticks    = data[CntW-1:0];
      CFG_PRESS_GAP_TICKS:   cfg_q.press_gap_ticks   = data[GapW-1:0];
      CFG_RELEASE_GAP_TICKS: cfg_q.release_gap_ticks = data[GapW-1:0];
      CFG_CLICK_LIMIT:       cfg_q.click_limit       = data[CntW-1:0];
      CFG_HOLD_ON_MIN:       cfg_q.hold_on_min       = data[HoldW-1:0];
      CFG_HOLD_ON_MAX:       cfg_q.hold_on_max       = data[HoldW-1:0];
      CFG_HOLD_OFF_TICKS:    cfg_q.hold_off_ticks    = data[HoldW-1:0];
      default: ;
    endcase
  endtask

  task automatic scan_tick(input logic mic, input logic key, input logic heat,
                           input logic [AdcW-1:0] adc, input logic [BatW-1:0] bat,
                           output res_t r);
    logic [ProdW-1:0]   prod;
    logic [BatW-1:0]    level;
    logic [SampleW-1:0] smp, rise, fall;
    prod  = ProdW'(adc) * ProdW'(bat);
    level = BatW'(prod >> 12);
    r = '0;
    smp = '0;
    smp[SbMic]  = mic;
    smp[SbUsb]  = (level >= cfg_q.usb_threshold);
    smp[SbKey]  = ~key;
    smp[SbHeat] = heat;

    if (smp != accepted_q) begin
      if (bounce_q < cfg_q.debounce_ticks) begin
        bounce_q = bounce_q + 1'b1;
      end else begin
        rise = smp & ~accepted_q;
        fall = ~smp & accepted_q;
        if (rise[SbMic]) begin
          power_q = 1'b1;
          out_q   = 1'b1;
        end
        if (fall[SbMic]) begin
          out_q = 1'b0;
          r.out_stop_event = 1'b1;
        end
        if (rise[SbKey]) begin
          gap_q  = cfg_q.press_gap_ticks;
          held_q = 1'b1;
          if (clicks_q < cfg_q.click_limit) clicks_q = clicks_q + 1'b1;
        end
        if (fall[SbKey]) begin
          gap_q  = cfg_q.release_gap_ticks;
          held_q = 1'b0;
        end
        if (rise[SbUsb]) begin
          usb_q = 1'b1;
          r.usb_attach_event = 1'b1;
        end
        if (fall[SbUsb]) begin
          usb_q = 1'b0;
          r.usb_detach_event = 1'b1;
        end
        if (rise[SbHeat]) heat_q = 1'b1;
        if (fall[SbHeat]) heat_q = 1'b0;
        bounce_q   = '0;
        accepted_q = smp;
      end
    end else begin
      bounce_q = '0;
    end

    if (held_q) begin
      if (hold_q != HoldMax) hold_q = hold_q + 1'b1;
      if (!power_q && hold_q >= cfg_q.hold_on_min && hold_q <= cfg_q.hold_on_max) begin
        r.display_on_event = 1'b1;
        power_q = 1'b1;
      end else if (hold_q >= cfg_q.hold_off_ticks) begin
        power_q = 1'b0;
        r.sleep_event = 1'b1;
      end
    end else begin
      hold_q = '0;
    end

    if (gap_q != 0) begin
      gap_q = gap_q - 1'b1;
    end else begin
      if (clicks_q == 1) begin
        gear_q = ~gear_q;
        r.gear_toggle_event = 1'b1;
        if (!power_q) r.display_on_event = 1'b1;
      end
      clicks_q = '0;
    end

    r.out_start = out_q;
    r.usb_in    = usb_q;
    r.heat_in   = heat_q;
    r.power_on  = power_q;
    r.gear_high = gear_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      = CfgReset;
      accepted_q = '0;
      bounce_q   = '0;
      held_q     = 1'b0;
      hold_q     = '0;
      gap_q      = '0;
      clicks_q   = '0;
      power_q    = 1'b0;
      gear_q     = 1'b0;
      out_q      = 1'b0;
      usb_q      = 1'b0;
      heat_q     = 1'b0;
      predicted_results.delete();
      pending_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) load_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
      if (out_valid_i && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with none expected, actual %b", $time, result_i);
          mismatch_count_o++;
        end else begin
          want = predicted_results.pop_front();
          for (int i = 0; i < ResW; i++) begin
            if (want[ResW-1-i] !== result_i[ResW-1-i]) begin
              $display("%0t: %s expected %0b actual %0b", $time, field_name[i],
                       want[ResW-1-i], result_i[ResW-1-i]);
              mismatch_count_o++;
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        scan_tick(mic_pin_i, key_pin_i, heat_pin_i, usb_adc_i, bat_volt_i, got);
        predicted_results.push_back(got);
      end
      pending_o = predicted_results.size();
    end
  end

endmodule

[verif/tb_port_debounce_click_long_press.sv]
`timescale 1ns / 100ps
// Testbench top for port_debounce_click_long_press: clock, reset, scan-tick and config
// stimulus, result-side stalls, watchdog and verdict.
// Depends on pdclp_pkg, the block RTL and pdclp_result_checker.
module tb_port_debounce_click_long_press;
  import pdclp_pkg::*;

  localparam int unsigned QuietLimit = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                mic_pin_i;
  logic                key_pin_i;
  logic                heat_pin_i;
  logic [AdcW-1:0]     usb_adc_i;
  logic [BatW-1:0]     bat_volt_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                out_start_o;
  logic                out_stop_event_o;
  logic                usb_attach_event_o;
  logic                usb_detach_event_o;
  logic                usb_in_o;
  logic                heat_in_o;
  logic                power_on_o;
  logic                display_on_event_o;
  logic                sleep_event_o;
  logic                gear_high_o;
  logic                gear_toggle_event_o;

  res_t        dut_result;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          no_gaps;
  cfg_t        cur_cfg;
  cfg_t        phase_cfg;
  logic        tgt_mic, tgt_key, tgt_heat, tgt_usb;

  port_debounce_click_long_press dut (.*);

  assign dut_result = {out_start_o, out_stop_event_o, usb_attach_event_o, usb_detach_event_o,
                       usb_in_o, heat_in_o, power_on_o, display_on_event_o, sleep_event_o,
                       gear_high_o, gear_toggle_event_o};

  pdclp_result_checker u_result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .mic_pin_i        (mic_pin_i),
    .key_pin_i        (key_pin_i),
    .heat_pin_i       (heat_pin_i),
    .usb_adc_i        (usb_adc_i),
    .bat_volt_i       (bat_volt_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_i         (dut_result),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned idle_length();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
  endfunction

  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!no_gaps && $urandom_range(0, 99) < 20) stall_left = idle_length();
      end
    end
  end

  task automatic send_tick(input logic mic, input logic key, input logic heat,
                           input logic [AdcW-1:0] adc, input logic [BatW-1:0] bat);
    int unsigned gap;
    gap = (no_gaps || $urandom_range(0, 99) < 60) ? 0 : idle_length();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mic_pin_i  <= mic;
    key_pin_i  <= key;
    heat_pin_i <= heat;
    usb_adc_i  <= adc;
    bat_volt_i <= bat;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic hold_ticks(input logic mic, input logic key, input logic heat,
                            input logic [AdcW-1:0] adc, input logic [BatW-1:0] bat,
                            input int unsigned n);
    repeat (n) send_tick(mic, key, heat, adc, bat);
  endtask

  // Pick an ADC and battery pair whose scaled level mostly lands on the wanted side of the threshold.
  task automatic make_reading(input logic want_high, output logic [AdcW-1:0] adc,
                              output logic [BatW-1:0] bat);
    int unsigned need, lim;
    adc  = AdcW'($urandom_range(1, 4095));
    bat  = BatW'($urandom);
    need = 32'(cur_cfg.usb_threshold) * 4096;
    if ($urandom_range(0, 4) == 0) begin
      adc = AdcW'($urandom);
    end else if (want_high) begin
      lim = (need + adc - 1) / adc;
      if (lim > 65535) begin
        adc = '1;
        lim = (need + 4094) / 4095;
      end
      if (lim > 65535) bat = '1;
      else bat = BatW'(($urandom_range(0, 3) == 0) ? lim : $urandom_range(lim, 65535));
    end else if (need != 0) begin
      lim = (need - 1) / adc;
      if (lim > 65535) lim = 65535;
      bat = BatW'(($urandom_range(0, 3) == 0) ? lim : $urandom_range(0, lim));
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_config(input cfg_t c);
    write_reg(CFG_USB_THRESHOLD, c.usb_threshold);
    write_reg(CFG_DEBOUNCE_TICKS, CfgDataW'(c.debounce_ticks));
    write_reg(CFG_PRESS_GAP_TICKS, CfgDataW'(c.press_gap_ticks));
    write_reg(CFG_RELEASE_GAP_TICKS, CfgDataW'(c.release_gap_ticks));
    write_reg(CFG_CLICK_LIMIT, CfgDataW'(c.click_limit));
    write_reg(CFG_HOLD_ON_MIN, CfgDataW'(c.hold_on_min));
    write_reg(CFG_HOLD_ON_MAX, CfgDataW'(c.hold_on_max));
    write_reg(CFG_HOLD_OFF_TICKS, CfgDataW'(c.hold_off_ticks));
    cfg_valid_i <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.usb_threshold     = ($urandom_range(0, 1) == 0) ? 16'($urandom) :
                                                        16'($urandom_range(50, 3000));
    c.debounce_ticks    = 4'($urandom_range(0, 4));
    c.press_gap_ticks   = 8'($urandom_range(0, 25));
    c.release_gap_ticks = 8'($urandom_range(0, 25));
    c.click_limit       = 4'($urandom_range(1, 15));
    c.hold_on_min       = 12'($urandom_range(0, 30));
    c.hold_on_max       = c.hold_on_min + 12'($urandom_range(0, 40));
    c.hold_off_ticks    = 12'($urandom_range(20, 150));
    return c;
  endfunction

  // Mostly debounce-clean runs of a stable pin pattern, with bounces and glitch ticks mixed in.
  task automatic run_random(input int unsigned n_items, input int unsigned span);
    int unsigned      sent, run, r, deb;
    logic [3:0]       flip;
    logic [AdcW-1:0]  adc;
    logic [BatW-1:0]  bat;
    sent = 0;
    deb  = cur_cfg.debounce_ticks;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      flip = '0;
      if (r < 55) flip[1] = 1'b1;
      else if (r < 65) flip[0] = 1'b1;
      else if (r < 72) flip[2] = 1'b1;
      else if (r < 80) flip[3] = 1'b1;
      else if (r < 90) flip = 4'($urandom);
      tgt_mic  ^= flip[0];
      tgt_key  ^= flip[1];
      tgt_heat ^= flip[2];
      tgt_usb  ^= flip[3];
      r = $urandom_range(0, 99);
      if (r < 76) run = deb + 1 + $urandom_range(0, 3);
      else if (r < 94) run = $urandom_range(1, deb + 1);
      else run = deb + 1 + $urandom_range(0, span);
      repeat (run) begin
        if ($urandom_range(0, 99) < 5) begin
          send_tick(1'($urandom), 1'($urandom), 1'($urandom), AdcW'($urandom),
                    BatW'($urandom));
        end else begin
          make_reading(tgt_usb, adc, bat);
          send_tick(tgt_mic, tgt_key, tgt_heat, adc, bat);
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    mic_pin_i   = 1'b0;
    key_pin_i   = 1'b1;
    heat_pin_i  = 1'b0;
    usb_adc_i   = '0;
    bat_volt_i  = '0;
    no_gaps     = 1'b0;
    tgt_mic     = 1'b0;
    tgt_key     = 1'b1;
    tgt_heat    = 1'b0;
    tgt_usb     = 1'b0;
    cur_cfg     = '{16'd350, 4'd3, 8'd50, 8'd30, 4'd10, 12'd300, 12'd1000, 12'd3000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: all edges at once, a glitch, then the threshold boundary.
    hold_ticks(1'b0, 1'b1, 1'b0, 12'd0, 16'd0, 2);
    hold_ticks(1'b1, 1'b0, 1'b1, 12'hFFF, 16'hFFFF, 5);
    hold_ticks(1'b0, 1'b1, 1'b0, 12'd0, 16'hFFFF, 1);
    hold_ticks(1'b0, 1'b1, 1'b0, 12'hFFF, 16'd0, 5);
    hold_ticks(1'b0, 1'b1, 1'b0, 12'd4000, 16'd359, 4);
    hold_ticks(1'b0, 1'b1, 1'b0, 12'd4000, 16'd358, 4);
    drain();

    write_config('{16'd0, 4'd0, 8'd0, 8'd0, 4'd1, 12'd0, 12'd0, 12'd0});
    run_random(100, 8);
    drain();

    write_config('{16'hFFFF, 4'd15, 8'hFF, 8'hFF, 4'd15, 12'hFFF, 12'hFFF, 12'hFFF});
    run_random(100, 40);
    drain();

    phase_cfg = random_cfg();
    phase_cfg.click_limit = '0;
    write_config(phase_cfg);
    run_random(100, phase_cfg.hold_off_ticks + 10);
    drain();

    phase_cfg = random_cfg();
    phase_cfg.hold_on_min = 12'd40;
    phase_cfg.hold_on_max = 12'd10;
    write_config(phase_cfg);
    run_random(100, phase_cfg.hold_off_ticks + 10);
    drain();

    no_gaps = 1'b1;
    phase_cfg = random_cfg();
    write_config(phase_cfg);
    run_random(100, phase_cfg.hold_off_ticks + 10);
    drain();
    no_gaps = 1'b0;

    repeat (2) begin
      phase_cfg = random_cfg();
      write_config(phase_cfg);
      run_random(100, phase_cfg.hold_off_ticks + 10);
      drain();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
